[sv/lpc_pkg.sv]
package lpc_pkg;

    localparam int MAX_SENSORS       = 11;
    localparam int SENSOR_TOTAL      = 11;
    localparam int SAMPLE_BITS       = 12;
    localparam int CALIBRATION_READS = 3;

    localparam int THRESHOLD_DIVISOR = 2 * CALIBRATION_READS;
    localparam int IDX_BITS          = $clog2(SENSOR_TOTAL);
    localparam int COUNT_BITS        = $clog2(CALIBRATION_READS + 1);
    localparam int SUM_BITS          = $clog2(CALIBRATION_READS * (2 ** SAMPLE_BITS - 1) + 1);
    localparam int THR_BITS          = SAMPLE_BITS - 1;
    localparam int EXC_BITS          = SAMPLE_BITS + 1;
    localparam int WEIGHT_BITS       = 5;
    localparam int PROD_BITS         = THR_BITS + 1 + WEIGHT_BITS;
    localparam int NUM_BITS          = THR_BITS + 7;
    localparam int DEN_BITS          = THR_BITS + $clog2(SENSOR_TOTAL);
    localparam int QUO_BITS          = 4;
    localparam int QBIT_BITS         = $clog2(QUO_BITS);
    localparam int ERR_BITS          = 5;
    localparam int RECIP_SHIFT       = SUM_BITS + 3;
    localparam int RECIP_BITS        = RECIP_SHIFT;
    localparam int RECIP             = (2 ** RECIP_SHIFT + THRESHOLD_DIVISOR - 1)
                                       / THRESHOLD_DIVISOR;

    localparam logic signed [WEIGHT_BITS-1:0] POSITION_WEIGHT [MAX_SENSORS] = '{
        -5'sd8, -5'sd6, -5'sd4, -5'sd3, -5'sd1, 5'sd0,
        5'sd1, 5'sd3, 5'sd4, 5'sd6, 5'sd8
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_EMIT
    } lpc_state_t;

    typedef struct packed {
        logic load;
        logic sweep;
        logic div_load;
        logic div_step;
        logic emit;
    } lpc_cmd_t;

    typedef struct packed {
        logic calibrate;
        logic last_sensor;
        logic last_bit;
        logic out_free;
    } lpc_status_t;

endpackage

[sv/line_position_centroid.sv]
// Channel   Handshake             Payload
// input     in_valid / in_ready   command, sample_0 .. sample_10
// output    out_valid / out_ready active_mask, line_error, line_found, calibration_done
//
// One transaction at a time: a measure frame runs an 11-step sensor sweep, a divider
// load, a 4-step restoring divider and emit before the next acceptance.
// A calibration frame skips the divider.
// Reset clears thresholds, calibration sums, frame count and held error at once.
// A stalled output holds the result register; the block waits in emit until it is free.
module line_position_centroid (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_0,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_1,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_2,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_3,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_4,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_5,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_6,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_7,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_8,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_9,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]     sample_10,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lpc_pkg::MAX_SENSORS-1:0]     active_mask,
    output logic signed [lpc_pkg::ERR_BITS-1:0] line_error,
    output logic                                line_found,
    output logic                                calibration_done
);

    logic [lpc_pkg::SAMPLE_BITS-1:0] samples [lpc_pkg::MAX_SENSORS];
    lpc_pkg::lpc_cmd_t               cmd;
    lpc_pkg::lpc_status_t            status;

    assign samples[0]  = sample_0;
    assign samples[1]  = sample_1;
    assign samples[2]  = sample_2;
    assign samples[3]  = sample_3;
    assign samples[4]  = sample_4;
    assign samples[5]  = sample_5;
    assign samples[6]  = sample_6;
    assign samples[7]  = sample_7;
    assign samples[8]  = sample_8;
    assign samples[9]  = sample_9;
    assign samples[10] = sample_10;

    lpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lpc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .command          (command),
        .samples          (samples),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .active_mask      (active_mask),
        .line_error       (line_error),
        .line_found       (line_found),
        .calibration_done (calibration_done)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    a_found_has_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_found) |-> (active_mask != '0))
        else $error("line found with empty active mask");

    a_cal_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && calibration_done) |-> (active_mask == '0 && !line_found))
        else $error("calibration result carries measure data");

    a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_error >= -5'sd8 && line_error <= 5'sd8))
        else $error("line error out of range");

endmodule

[sv/lpc_ctrl.sv]
module lpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpc_pkg::lpc_status_t status,
    output lpc_pkg::lpc_cmd_t    cmd
);

    lpc_pkg::lpc_state_t state_reg;
    lpc_pkg::lpc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lpc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lpc_pkg::ST_SWEEP;
                end
            end
            lpc_pkg::ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.last_sensor)
                begin
                    state_next = status.calibrate ? lpc_pkg::ST_EMIT : lpc_pkg::ST_DIV_LOAD;
                end
            end
            lpc_pkg::ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = lpc_pkg::ST_DIV_RUN;
            end
            lpc_pkg::ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (status.last_bit)
                begin
                    state_next = lpc_pkg::ST_EMIT;
                end
            end
            lpc_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = lpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/lpc_datapath.sv]
module lpc_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lpc_pkg::lpc_cmd_t                      cmd,
    output lpc_pkg::lpc_status_t                   status,
    input  logic                                   command,
    input  logic [lpc_pkg::SAMPLE_BITS-1:0]        samples [lpc_pkg::MAX_SENSORS],
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [lpc_pkg::MAX_SENSORS-1:0]        active_mask,
    output logic signed [lpc_pkg::ERR_BITS-1:0]    line_error,
    output logic                                   line_found,
    output logic                                   calibration_done
);

    logic                                 cal_reg;
    logic [lpc_pkg::SAMPLE_BITS-1:0]      frame_reg [lpc_pkg::SENSOR_TOTAL];
    logic [lpc_pkg::IDX_BITS-1:0]         idx_reg;
    logic [lpc_pkg::THR_BITS-1:0]         thr_reg [lpc_pkg::SENSOR_TOTAL];
    logic [lpc_pkg::SUM_BITS-1:0]         sum_reg [lpc_pkg::SENSOR_TOTAL];
    logic [lpc_pkg::COUNT_BITS-1:0]       count_reg;
    logic [lpc_pkg::SENSOR_TOTAL-1:0]     mask_reg;
    logic signed [lpc_pkg::NUM_BITS-1:0]  num_reg;
    logic [lpc_pkg::DEN_BITS-1:0]         den_reg;
    logic [lpc_pkg::NUM_BITS-1:0]         rem_reg;
    logic [lpc_pkg::QUO_BITS-1:0]         quo_reg;
    logic                                 neg_reg;
    logic [lpc_pkg::QBIT_BITS-1:0]        bit_reg;
    logic signed [lpc_pkg::ERR_BITS-1:0]  held_reg;
    logic                                 out_valid_reg;
    logic [lpc_pkg::MAX_SENSORS-1:0]      mask_out_reg;
    logic signed [lpc_pkg::ERR_BITS-1:0]  err_out_reg;
    logic                                 found_out_reg;
    logic                                 done_out_reg;

    logic [lpc_pkg::SAMPLE_BITS-1:0]                      sample_sel;
    logic [lpc_pkg::THR_BITS-1:0]                         thr_sel;
    logic signed [lpc_pkg::EXC_BITS-1:0]                  excess;
    logic                                                 active;
    logic [lpc_pkg::THR_BITS-1:0]                         exc_mag;
    logic signed [lpc_pkg::PROD_BITS-1:0]                 weighted;
    logic                                                 last_cal;
    logic [lpc_pkg::SUM_BITS-1:0]                         sum_base;
    logic [lpc_pkg::SUM_BITS-1:0]                         sum_new;
    logic [lpc_pkg::SUM_BITS+lpc_pkg::RECIP_BITS-1:0]     recip_prod;
    logic [lpc_pkg::THR_BITS-1:0]                         thr_new;
    logic [lpc_pkg::NUM_BITS-1:0]                         num_mag;
    logic [lpc_pkg::NUM_BITS-1:0]                         den_shift;
    logic                                                 den_fits;
    logic                                                 found;
    logic signed [lpc_pkg::ERR_BITS-1:0]                  quo_signed;
    logic signed [lpc_pkg::ERR_BITS-1:0]                  err_new;

    assign sample_sel = frame_reg[idx_reg];
    assign thr_sel    = thr_reg[idx_reg];
    assign excess     = $signed({2'b00, thr_sel}) - $signed({1'b0, sample_sel});
    assign active     = !excess[lpc_pkg::EXC_BITS-1] && (excess != '0);
    assign exc_mag    = excess[lpc_pkg::THR_BITS-1:0];
    assign weighted   = lpc_pkg::PROD_BITS'($signed({1'b0, exc_mag}))
                        * lpc_pkg::PROD_BITS'(lpc_pkg::POSITION_WEIGHT[idx_reg]);

    assign last_cal   = (count_reg == lpc_pkg::COUNT_BITS'(lpc_pkg::CALIBRATION_READS - 1));
    assign sum_base   = (count_reg == '0) ? '0 : sum_reg[idx_reg];
    assign sum_new    = sum_base + lpc_pkg::SUM_BITS'(sample_sel);
    assign recip_prod = (lpc_pkg::SUM_BITS + lpc_pkg::RECIP_BITS)'(sum_new)
                        * (lpc_pkg::SUM_BITS + lpc_pkg::RECIP_BITS)'(lpc_pkg::RECIP);
    assign thr_new    = recip_prod[lpc_pkg::RECIP_SHIFT +: lpc_pkg::THR_BITS];

    assign num_mag    = num_reg[lpc_pkg::NUM_BITS-1] ? lpc_pkg::NUM_BITS'(-num_reg)
                                                     : lpc_pkg::NUM_BITS'(num_reg);
    assign den_shift  = lpc_pkg::NUM_BITS'(den_reg) << bit_reg;
    assign den_fits   = (rem_reg >= den_shift);

    assign found      = !cal_reg && (den_reg != '0);
    assign quo_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign err_new    = found ? quo_signed : held_reg;

    assign status.calibrate   = cal_reg;
    assign status.last_sensor = (idx_reg == lpc_pkg::IDX_BITS'(lpc_pkg::SENSOR_TOTAL - 1));
    assign status.last_bit    = (bit_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg       <= 1'b0;
            idx_reg       <= '0;
            bit_reg       <= '0;
            count_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lpc_pkg::SENSOR_TOTAL; i++)
            begin
                thr_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                cal_reg <= command;
                idx_reg <= '0;
            end
            if (cmd.sweep)
            begin
                idx_reg <= idx_reg + lpc_pkg::IDX_BITS'(1);
                if (cal_reg)
                begin
                    sum_reg[idx_reg] <= sum_new;
                    if (last_cal)
                    begin
                        thr_reg[idx_reg] <= thr_new;
                    end
                end
            end
            if (cmd.div_load)
            begin
                bit_reg <= lpc_pkg::QBIT_BITS'(lpc_pkg::QUO_BITS - 1);
            end
            if (cmd.div_step)
            begin
                bit_reg <= bit_reg - lpc_pkg::QBIT_BITS'(1);
            end
            if (cmd.emit)
            begin
                held_reg <= err_new;
                if (cal_reg)
                begin
                    count_reg <= last_cal ? '0 : count_reg + lpc_pkg::COUNT_BITS'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < lpc_pkg::SENSOR_TOTAL; i++)
            begin
                frame_reg[i] <= samples[i];
            end
            mask_reg <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
        end
        if (cmd.sweep && !cal_reg && active)
        begin
            mask_reg[idx_reg] <= 1'b1;
            num_reg           <= num_reg + lpc_pkg::NUM_BITS'(weighted);
            den_reg           <= den_reg + lpc_pkg::DEN_BITS'(exc_mag);
        end
        if (cmd.div_load)
        begin
            rem_reg <= num_mag;
            neg_reg <= num_reg[lpc_pkg::NUM_BITS-1];
            quo_reg <= '0;
        end
        if (cmd.div_step && den_fits)
        begin
            rem_reg          <= rem_reg - den_shift;
            quo_reg[bit_reg] <= 1'b1;
        end
        if (cmd.emit)
        begin
            mask_out_reg  <= cal_reg ? '0 : lpc_pkg::MAX_SENSORS'(mask_reg);
            err_out_reg   <= err_new;
            found_out_reg <= found;
            done_out_reg  <= cal_reg && last_cal;
        end
    end

    assign out_valid        = out_valid_reg;
    assign active_mask      = mask_out_reg;
    assign line_error       = err_out_reg;
    assign line_found       = found_out_reg;
    assign calibration_done = done_out_reg;

endmodule
